// ===== design/block_read_request_splitter_core_assert.svh =====
// Assertion macros used by the block read request splitter top level
`ifndef BLOCK_READ_REQUEST_SPLITTER_CORE_ASSERT_SVH
`define BLOCK_READ_REQUEST_SPLITTER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define BRS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("brs assertion failed");

// Next-cycle implication, checked at every rising edge outside reset
`define BRS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("brs assertion failed");

`endif

// ===== design/brs_pkg.sv =====
// Types and constants of the block read request splitter
`default_nettype none

package brs_pkg;

	// Stream and register port geometry
	localparam int IN_TDATA_W  = 168;
	localparam int OUT_TDATA_W = 216;
	localparam int APB_ADDR_W  = 6;
	localparam int APB_DATA_W  = 64;

	// Fixed behaviour constants
	localparam logic [3:0]  MAX_RETRIES   = 4'd3;
	localparam logic [23:0] DEFAULT_CHUNK = 24'd1024;
	localparam logic [5:0]  PAGE_SHIFT    = 6'd12;
	localparam logic [4:0]  CHUNK_EXP_MAX = 5'd23;

	// Input transaction kind (tuser)
	localparam logic CMD_REQUEST    = 1'b0;
	localparam logic CMD_COMPLETION = 1'b1;

	// Result transaction kind (tuser)
	localparam logic KIND_ISSUE  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// Completion status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_BAD_SIZE = 2'd1;
	localparam logic [1:0] STATUS_INVALID  = 2'd2;
	localparam logic [1:0] STATUS_DEVICE   = 2'd3;

	// Register indexes (byte address is 8 times the index)
	localparam logic [2:0] REG_MAX_XFER_EXP = 3'd0;
	localparam logic [2:0] REG_MIN_PAGE_EXP = 3'd1;
	localparam logic [2:0] REG_BLOCK_LOG2   = 3'd2;
	localparam logic [2:0] REG_LAST_BLOCK   = 3'd3;
	localparam logic [2:0] REG_NAMESPACE    = 3'd4;

	typedef struct packed {
		logic [3:0]  max_transfer_exponent;
		logic [2:0]  min_page_exponent;
		logic [3:0]  block_size_log2;
		logic [63:0] last_block;
		logic [31:0] namespace_id;
	} brs_cfg_t;

	typedef struct packed {
		logic        command;
		logic [63:0] start_lba;
		logic [31:0] buffer_bytes;
		logic [63:0] buffer_address;
		logic        completion_ok;
	} brs_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  status;
		logic [63:0] cmd_lba;
		logic [15:0] cmd_blocks_minus_one;
		logic [31:0] cmd_bytes;
		logic [63:0] cmd_address;
		logic [31:0] cmd_namespace;
	} brs_result_t;

	typedef struct packed {
		logic        busy;
		logic [31:0] remaining_blocks;
		logic [63:0] current_lba;
		logic [63:0] current_address;
		logic [23:0] max_chunk_blocks;
		logic [3:0]  retry_count;
	} brs_state_t;

	typedef struct packed {
		logic        accept;
		logic [1:0]  status;
		logic [31:0] blocks;
		logic [23:0] chunk;
	} brs_check_t;

endpackage

`default_nettype wire

// ===== design/brs_regs.sv =====
// APB register file holding the namespace geometry and transfer limits
`default_nettype none

module brs_regs import brs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output brs_cfg_t                   cfg
);

	logic       wr_en;
	logic [2:0] reg_idx;
	brs_cfg_t   cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[5:3];
	assign cfg     = cfg_q;

	// Write the addressed register; ignore addresses past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_transfer_exponent <= 4'd0;
			cfg_q.min_page_exponent     <= 3'd0;
			cfg_q.block_size_log2       <= 4'd9;
			cfg_q.last_block            <= 64'd0;
			cfg_q.namespace_id          <= 32'd1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_MAX_XFER_EXP: cfg_q.max_transfer_exponent <= pwdata[3:0];
				REG_MIN_PAGE_EXP: cfg_q.min_page_exponent     <= pwdata[2:0];
				REG_BLOCK_LOG2:   cfg_q.block_size_log2       <= pwdata[3:0];
				REG_LAST_BLOCK:   cfg_q.last_block            <= pwdata;
				REG_NAMESPACE:    cfg_q.namespace_id          <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero elsewhere
	always_comb begin
		unique case (reg_idx)
			REG_MAX_XFER_EXP: prdata = {60'd0, cfg_q.max_transfer_exponent};
			REG_MIN_PAGE_EXP: prdata = {61'd0, cfg_q.min_page_exponent};
			REG_BLOCK_LOG2:   prdata = {60'd0, cfg_q.block_size_log2};
			REG_LAST_BLOCK:   prdata = cfg_q.last_block;
			REG_NAMESPACE:    prdata = {32'd0, cfg_q.namespace_id};
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/brs_check.sv =====
// New request validation and largest-transfer calculation
`default_nettype none

module brs_check import brs_pkg::*; (
	input  wire brs_cfg_t     cfg,
	input  wire logic [63:0]  lba,
	input  wire logic [31:0]  bytes,
	input  wire logic [63:0]  addr,
	output brs_check_t        chk
);

	logic [31:0] size_mask;
	logic [31:0] blocks;
	logic [31:0] blocks_m1;
	logic [63:0] span;
	logic [5:0]  exp_sum;
	logic [5:0]  exp_diff;
	logic [23:0] chunk;

	// Block size is a power of two: mask for remainder, shift for quotient
	assign size_mask = (32'd1 << cfg.block_size_log2) - 32'd1;
	assign blocks    = bytes >> cfg.block_size_log2;
	assign blocks_m1 = blocks - 32'd1;
	assign span      = cfg.last_block - lba;

	// Largest transfer in blocks, clamped to one block and to 2^23; 1024 blocks when the exponent is zero
	assign exp_sum  = {2'd0, cfg.max_transfer_exponent} + {3'd0, cfg.min_page_exponent}
		+ PAGE_SHIFT;
	assign exp_diff = exp_sum - {2'd0, cfg.block_size_log2};

	always_comb begin
		if (cfg.max_transfer_exponent == 4'd0) begin
			chunk = DEFAULT_CHUNK;
		end else if (exp_sum < {2'd0, cfg.block_size_log2}) begin
			chunk = 24'd1;
		end else if (exp_diff > {1'b0, CHUNK_EXP_MAX}) begin
			chunk = 24'd1 << CHUNK_EXP_MAX;
		end else begin
			chunk = 24'd1 << exp_diff[4:0];
		end
	end

	// Check in order of precedence
	always_comb begin
		chk.blocks = blocks;
		chk.chunk  = chunk;
		chk.accept = 1'b0;
		priority if (addr == 64'd0) begin
			chk.status = STATUS_INVALID;
		end else if (bytes == 32'd0) begin
			chk.status = STATUS_OK;
		end else if ((bytes & size_mask) != 32'd0) begin
			chk.status = STATUS_BAD_SIZE;
		end else if (lba > cfg.last_block) begin
			chk.status = STATUS_INVALID;
		end else if ({32'd0, blocks_m1} > span) begin
			chk.status = STATUS_INVALID;
		end else begin
			chk.status = STATUS_OK;
			chk.accept = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== design/brs_step.sv =====
// Next-state and result logic for one request or completion transaction
`default_nettype none

module brs_step import brs_pkg::*; (
	input  wire brs_item_t  item,
	input  wire brs_state_t state,
	input  wire brs_cfg_t   cfg,
	output logic        has_result,
	output brs_result_t result,
	output brs_state_t  state_next
);

	brs_check_t  chk;
	logic [31:0] chunk32;
	logic [23:0] halved;
	logic [31:0] rem_after;
	logic [63:0] lba_adv;
	logic [63:0] addr_adv;
	logic [31:0] n_new;
	logic [31:0] n_adv;
	logic [31:0] n_retry;

	brs_check u_check (
		.cfg   (cfg),
		.lba   (item.start_lba),
		.bytes (item.buffer_bytes),
		.addr  (item.buffer_address),
		.chk   (chk)
	);

	function automatic brs_result_t make_issue(input logic [63:0] lba, input logic [63:0] addr,
		input logic [31:0] n, input logic [3:0] sh, input logic [31:0] nsid);
		brs_result_t r;
		r.result_kind          = KIND_ISSUE;
		r.status               = STATUS_OK;
		r.cmd_lba              = lba;
		r.cmd_blocks_minus_one = 16'(n - 32'd1);
		r.cmd_bytes            = n << sh;
		r.cmd_address          = addr;
		r.cmd_namespace        = nsid;
		return r;
	endfunction

	function automatic brs_result_t make_finish(input logic [1:0] st);
		brs_result_t r;
		r             = '0;
		r.result_kind = KIND_FINISH;
		r.status      = st;
		return r;
	endfunction

	// Advance and retry figures, worked out side by side
	assign chunk32   = {8'd0, state.max_chunk_blocks};
	assign halved    = state.max_chunk_blocks >> 1;
	assign rem_after = state.remaining_blocks - chunk32;
	assign lba_adv   = state.current_lba + {40'd0, state.max_chunk_blocks};
	assign addr_adv  = state.current_address
		+ ({40'd0, state.max_chunk_blocks} << cfg.block_size_log2);
	assign n_new     = (chk.blocks > {8'd0, chk.chunk}) ? {8'd0, chk.chunk} : chk.blocks;
	assign n_adv     = (state.remaining_blocks > {7'd0, state.max_chunk_blocks, 1'b0})
		? chunk32 : rem_after;
	assign n_retry   = (state.remaining_blocks > {8'd0, halved})
		? {8'd0, halved} : state.remaining_blocks;

	always_comb begin
		state_next = state;
		has_result = 1'b0;
		result     = '0;
		if (item.command == CMD_REQUEST) begin
			// New request: abandon anything in flight
			has_result      = 1'b1;
			state_next.busy = 1'b0;
			if (!chk.accept) begin
				result = make_finish(chk.status);
			end else begin
				state_next.busy             = 1'b1;
				state_next.remaining_blocks = chk.blocks;
				state_next.current_lba      = item.start_lba;
				state_next.current_address  = item.buffer_address;
				state_next.max_chunk_blocks = chk.chunk;
				state_next.retry_count      = 4'd0;
				result = make_issue(item.start_lba, item.buffer_address, n_new,
					cfg.block_size_log2, cfg.namespace_id);
			end
		end else if (state.busy) begin
			has_result = 1'b1;
			if (item.completion_ok) begin
				// Success: move on to the next piece or finish
				if (state.remaining_blocks > chunk32) begin
					state_next.remaining_blocks = rem_after;
					state_next.current_lba      = lba_adv;
					state_next.current_address  = addr_adv;
					result = make_issue(lba_adv, addr_adv, n_adv,
						cfg.block_size_log2, cfg.namespace_id);
				end else begin
					state_next.remaining_blocks = 32'd0;
					state_next.busy             = 1'b0;
					result = make_finish(STATUS_OK);
				end
			end else begin
				// Failure: halve the chunk and retry, or give up
				state_next.max_chunk_blocks = halved;
				if (state.retry_count >= MAX_RETRIES || halved == 24'd0) begin
					state_next.busy = 1'b0;
					result = make_finish(STATUS_DEVICE);
				end else begin
					state_next.retry_count = state.retry_count + 4'd1;
					result = make_issue(state.current_lba, state.current_address, n_retry,
						cfg.block_size_log2, cfg.namespace_id);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/block_read_request_splitter_core.sv =====
// Top level of the block read request splitter
`default_nettype none

// Block read request splitter. A request transaction (tuser 0) carries a
// start block, a byte length and a destination address; the block checks it
// against the namespace registers and answers with either a finish result
// or the first read command. Each completion transaction (tuser 1) yields
// the next command, a retry with half the chunk after a failure, or the
// finish status; a completion with no request in flight yields nothing.
// A result passes through one input register, one pass of compare, shift
// and add logic that also updates the request state, and one result
// register. One transaction can be accepted every cycle; throughput is
// bounded only by the result register draining on the master side.
// Registers sit at byte addresses 0, 8, 16, 24 and 32 on the 64-bit APB
// port; the user must write them only while no transaction is in the
// pipeline, as the block itself does not enforce this.
module block_read_request_splitter_core import brs_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Request / completion stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [63:0] start_lba, [95:64] buffer_bytes, [159:96] buffer_address,
	// [160] completion_ok, [167:161] zero
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// [0] command
	input  wire logic                   s_tuser,
	// Result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [1:0] status, [65:2] cmd_lba, [81:66] cmd_blocks_minus_one,
	// [113:82] cmd_bytes, [177:114] cmd_address, [209:178] cmd_namespace,
	// [215:210] zero
	output logic      [OUT_TDATA_W-1:0] m_tdata,
	// [0] result_kind
	output logic                        m_tuser,
	// Configuration port
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_ADDR_W-1:0]  paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	output logic      [APB_DATA_W-1:0]  prdata,
	output logic                        pready
);

	brs_cfg_t    cfg;
	brs_item_t   item_s1;
	logic        valid_s1;
	brs_state_t  state_q;
	brs_state_t  state_next;
	logic        has_result;
	brs_result_t result;
	brs_result_t out_s2;
	logic        valid_s2;
	logic        out_free;
	logic        advance;

	brs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	brs_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.cfg        (cfg),
		.has_result (has_result),
		.result     (result),
		.state_next (state_next)
	);

	// Move the stage on when its result, if any, has room
	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && (!has_result || out_free);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command        <= s_tuser;
			item_s1.start_lba      <= s_tdata[63:0];
			item_s1.buffer_bytes   <= s_tdata[95:64];
			item_s1.buffer_address <= s_tdata[159:96];
			item_s1.completion_ok  <= s_tdata[160];
		end
	end

	// Request state, updated as each transaction leaves the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && has_result) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			out_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = out_s2.result_kind;
	assign m_tdata  = {6'd0, out_s2.cmd_namespace, out_s2.cmd_address, out_s2.cmd_bytes,
		out_s2.cmd_blocks_minus_one, out_s2.cmd_lba, out_s2.status};

	`include "block_read_request_splitter_core_assert.svh"

	// A request in flight always has a usable chunk and a bounded retry count
	`BRS_ASSERT_IMP(a_busy_chunk, clk, arst_n, state_q.busy, state_q.max_chunk_blocks != 24'd0)
	`BRS_ASSERT_IMP(a_retry_bound, clk, arst_n, 1'b1, state_q.retry_count <= MAX_RETRIES)
	// Finish results carry no command; issued commands carry success status
	`BRS_ASSERT_IMP(a_finish_clean, clk, arst_n, valid_s2 && out_s2.result_kind == KIND_FINISH,
		out_s2.cmd_lba == 64'd0 && out_s2.cmd_address == 64'd0 && out_s2.cmd_bytes == 32'd0)
	`BRS_ASSERT_IMP(a_issue_status, clk, arst_n, valid_s2 && out_s2.result_kind == KIND_ISSUE,
		out_s2.status == STATUS_OK)
	// A stalled stage holding a result must not lose it
	`BRS_ASSERT_NXT(a_stall_hold, clk, arst_n, valid_s1 && has_result && valid_s2 && !m_tready,
		valid_s1)

endmodule

`default_nettype wire
